FILE: rtl/las_pkg.sv
// Shared types and codes of the lift actuator supervisor.
`timescale 1ns / 1ps

package las_pkg;

  // Beat kinds carried in the mode field; 4 to 7 are unrecognized commands.
  localparam logic [2:0] MODE_TICK = 3'd0;
  localparam logic [2:0] MODE_STOP = 3'd1;
  localparam logic [2:0] MODE_UP   = 3'd2;
  localparam logic [2:0] MODE_DOWN = 3'd3;

  // Motor commands.
  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_UP   = 2'd1;
  localparam logic [1:0] DRV_DOWN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAX_UP   = 2'd0;
  localparam logic [1:0] CFG_MAX_DOWN = 2'd1;
  localparam logic [1:0] CFG_CMD_TO   = 2'd2;

  localparam logic [15:0] MAX_UP_RST   = 16'd10000;
  localparam logic [15:0] MAX_DOWN_RST = 16'd10000;
  localparam logic [15:0] CMD_TO_RST   = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_MOVING_UP   = 3'd1,
    ST_MOVING_DOWN = 3'd2,
    ST_AT_TOP      = 3'd3,
    ST_AT_BOTTOM   = 3'd4,
    ST_ERROR       = 3'd5
  } lift_state_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_LIMIT_CONFLICT = 3'd1,
    ERR_TOP_TIMEOUT    = 3'd2,
    ERR_BOTTOM_TIMEOUT = 3'd3,
    ERR_CMD_TIMEOUT    = 3'd4,
    ERR_INVALID        = 3'd5
  } lift_err_e;

  // One result beat as the core produces it.
  typedef struct packed {
    logic        moving;
    lift_err_e   error_code;
    lift_state_e lift_state;
    logic [1:0]  motor_drive;
  } las_res_t;

endpackage

FILE: rtl/las_core.sv
// Next-state and result logic of the lift supervisor for one beat.
`timescale 1ns / 1ps

module las_core #(
  parameter int CntW = 17
) (
  input  logic [2:0]              mode_i,
  input  logic                    upper_limit_i,
  input  logic                    lower_limit_i,
  input  las_pkg::lift_state_e    state_i,
  input  las_pkg::lift_err_e      err_i,
  input  logic [CntW-1:0]         motion_cnt_i,
  input  logic [CntW-1:0]         cmd_cnt_i,
  input  logic [15:0]             max_up_i,
  input  logic [15:0]             max_down_i,
  input  logic [15:0]             cmd_to_i,
  output las_pkg::lift_state_e    state_o,
  output las_pkg::lift_err_e      err_o,
  output logic [CntW-1:0]         motion_cnt_o,
  output logic [CntW-1:0]         cmd_cnt_o,
  output las_pkg::las_res_t       res_o
);
  import las_pkg::*;

  logic [CntW-1:0] motion_inc;
  logic [CntW-1:0] cmd_inc;
  logic [CntW-1:0] max_up_ext;
  logic [CntW-1:0] max_down_ext;
  logic [CntW-1:0] cmd_to_ext;
  logic            both_lim;
  logic            was_moving;
  logic            upward;
  logic            dir_lim;
  lift_state_e     target;

  // Both counters saturate at all ones.
  assign motion_inc = (&motion_cnt_i) ? motion_cnt_i : motion_cnt_i + 1'b1;
  assign cmd_inc    = (&cmd_cnt_i) ? cmd_cnt_i : cmd_cnt_i + 1'b1;

  assign max_up_ext   = {{(CntW-16){1'b0}}, max_up_i};
  assign max_down_ext = {{(CntW-16){1'b0}}, max_down_i};
  assign cmd_to_ext   = {{(CntW-16){1'b0}}, cmd_to_i};

  assign both_lim   = upper_limit_i & lower_limit_i;
  assign was_moving = (state_i == ST_MOVING_UP) || (state_i == ST_MOVING_DOWN);
  assign upward     = (mode_i == MODE_UP);
  assign dir_lim    = upward ? upper_limit_i : lower_limit_i;
  assign target     = upward ? ST_MOVING_UP : ST_MOVING_DOWN;

  always_comb begin
    state_o      = state_i;
    err_o        = err_i;
    motion_cnt_o = motion_cnt_i;
    cmd_cnt_o    = cmd_cnt_i;
    case (mode_i)
      MODE_TICK: begin
        motion_cnt_o = motion_inc;
        cmd_cnt_o    = cmd_inc;
        // Checks in priority order; the first one that fires wins.
        if (both_lim) begin
          state_o = ST_ERROR;
          err_o   = ERR_LIMIT_CONFLICT;
        end else if (state_i == ST_MOVING_UP && upper_limit_i) begin
          state_o = ST_AT_TOP;
          err_o   = ERR_NONE;
        end else if (state_i == ST_MOVING_DOWN && lower_limit_i) begin
          state_o = ST_AT_BOTTOM;
          err_o   = ERR_NONE;
        end else if (state_i == ST_MOVING_UP && motion_inc > max_up_ext) begin
          state_o = ST_ERROR;
          err_o   = ERR_TOP_TIMEOUT;
        end else if (state_i == ST_MOVING_DOWN && motion_inc > max_down_ext) begin
          state_o = ST_ERROR;
          err_o   = ERR_BOTTOM_TIMEOUT;
        end else if (was_moving && cmd_inc > cmd_to_ext) begin
          state_o = ST_ERROR;
          err_o   = ERR_CMD_TIMEOUT;
        end
      end
      MODE_STOP: begin
        motion_cnt_o = '0;
        cmd_cnt_o    = '0;
        state_o      = ST_IDLE;
        err_o        = ERR_NONE;
      end
      MODE_UP, MODE_DOWN: begin
        if (state_i != ST_ERROR) begin
          cmd_cnt_o = '0;
          if (both_lim) begin
            state_o = ST_ERROR;
            err_o   = ERR_LIMIT_CONFLICT;
          end else if (dir_lim) begin
            state_o = upward ? ST_AT_TOP : ST_AT_BOTTOM;
            err_o   = ERR_NONE;
          end else begin
            state_o = target;
            err_o   = ERR_NONE;
            // A repeated command in the same direction keeps the motion time.
            if (state_i != target) begin
              motion_cnt_o = '0;
            end
          end
        end
      end
      default: begin
        if (state_i != ST_ERROR) begin
          state_o = ST_ERROR;
          err_o   = ERR_INVALID;
        end
      end
    endcase
  end

  always_comb begin
    res_o.lift_state = state_o;
    res_o.error_code = err_o;
    res_o.moving     = (state_o == ST_MOVING_UP) || (state_o == ST_MOVING_DOWN);
    case (state_o)
      ST_MOVING_UP:   res_o.motor_drive = DRV_UP;
      ST_MOVING_DOWN: res_o.motor_drive = DRV_DOWN;
      default:        res_o.motor_drive = DRV_STOP;
    endcase
  end

endmodule

FILE: rtl/lift_actuator_supervisor.sv
// Top level of the lift actuator supervisor: beat registers, state and config.
//
//   Channel    Direction  Fields (lowest bit first)
//   s_axis     in         tdata: mode[2:0], upper_limit[3], lower_limit[4]
//   m_axis     out        tdata: motor_drive[1:0], lift_state[4:2],
//                                error_code[7:5], moving[8]
//   cfg        in         cfg_idx_i 0 max up time, 1 max down time,
//                         2 command timeout; 16-bit data
//
// Every input beat gives exactly one result beat. A beat is captured in the
// input register; when it moves on, the supervisor state is updated and the
// result is loaded into the output register in the same cycle, and one beat
// is taken per cycle while the output is not stalled. Reset puts the lift in
// idle with no error, clears both counters and loads the default limits. When
// the output is stalled the input register still takes one more beat before
// s_axis_tready drops.
`timescale 1ns / 1ps

module lift_actuator_supervisor #(
  parameter int COUNTER_BITS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // mode[2:0], upper_limit[3], lower_limit[4]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // motor_drive[1:0], lift_state[4:2],
                                      // error_code[7:5], moving[8]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import las_pkg::*;

  // Input beat register.
  logic       in_vld_q;
  logic [2:0] in_mode_q;
  logic       in_up_q;
  logic       in_lo_q;

  // Result register.
  logic     out_vld_q;
  las_res_t out_res_q;

  // Supervisor state.
  lift_state_e             state_q, state_d;
  lift_err_e               err_q, err_d;
  logic [COUNTER_BITS-1:0] motion_q, motion_d;
  logic [COUNTER_BITS-1:0] cmd_q, cmd_d;

  // Configuration.
  logic [15:0] max_up_q;
  logic [15:0] max_down_q;
  logic [15:0] cmd_to_q;

  las_res_t res_d;
  logic     adv;

  // The result register moves when it is empty or being drained; the input
  // register moves when it is empty or its beat is going on to the output.
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  las_core #(
    .CntW (COUNTER_BITS)
  ) u_core (
    .mode_i        (in_mode_q),
    .upper_limit_i (in_up_q),
    .lower_limit_i (in_lo_q),
    .state_i       (state_q),
    .err_i         (err_q),
    .motion_cnt_i  (motion_q),
    .cmd_cnt_i     (cmd_q),
    .max_up_i      (max_up_q),
    .max_down_i    (max_down_q),
    .cmd_to_i      (cmd_to_q),
    .state_o       (state_d),
    .err_o         (err_d),
    .motion_cnt_o  (motion_d),
    .cmd_cnt_o     (cmd_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_mode_q <= s_axis_tdata[2:0];
      in_up_q   <= s_axis_tdata[3];
      in_lo_q   <= s_axis_tdata[4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res_d;
    end
  end

  // The state only changes when a beat is committed to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      err_q    <= ERR_NONE;
      motion_q <= '0;
      cmd_q    <= '0;
    end else if (adv) begin
      state_q  <= state_d;
      err_q    <= err_d;
      motion_q <= motion_d;
      cmd_q    <= cmd_d;
    end
  end

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_up_q   <= MAX_UP_RST;
      max_down_q <= MAX_DOWN_RST;
      cmd_to_q   <= CMD_TO_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_UP:   max_up_q   <= cfg_data_i;
        CFG_MAX_DOWN: max_down_q <= cfg_data_i;
        CFG_CMD_TO:   cmd_to_q   <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_res_q};

endmodule

FILE: rtl/las_checker.sv
// Port-level checks of the lift actuator supervisor and their binding.
`timescale 1ns / 1ps

module las_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  import las_pkg::*;

  logic [1:0] drive;
  logic [2:0] st;
  logic [2:0] err;
  logic       mov;
  logic       in_beat;

  assign drive   = m_axis_tdata[1:0];
  assign st      = m_axis_tdata[4:2];
  assign err     = m_axis_tdata[7:5];
  assign mov     = m_axis_tdata[8];
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // A stalled result beat stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // The moving flag follows the reported state.
  a_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (mov == ((st == ST_MOVING_UP) || (st == ST_MOVING_DOWN))))
    else $error("moving flag disagrees with state");

  // The motor only runs in the matching moving state.
  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ((drive == DRV_UP) == (st == ST_MOVING_UP)) &&
      ((drive == DRV_DOWN) == (st == ST_MOVING_DOWN)))
    else $error("motor drive disagrees with state");

  // An error code is reported exactly in the error state.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((st == ST_ERROR) == (err != ERR_NONE)))
    else $error("error code disagrees with state");

  // An accepted input beat yields a result beat through the input and result
  // registers when the output is not stalled.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result beat missing");

endmodule

bind lift_actuator_supervisor las_checker u_las_checker (.*);

FILE: test/testbench.sv
// Testbench of the lift actuator supervisor: directed table, random move runs, predictor check.
`timescale 1ns / 1ps

module testbench;
  import las_pkg::*;

  localparam int          COUNTER_BITS     = 17;
  localparam logic [2:0]  MODE_UNKNOWN     = 3'd4;
  localparam logic [2:0]  MODE_UNKNOWN_TOP = 3'd7;
  localparam logic [15:0] CFG_TOP          = 16'hFFFF;
  localparam int          REPORT_LIMIT     = 10;

  // A directed row is a beat checked against typed-in values, a beat checked
  // against the predictor, or a register write made once the block is idle.
  typedef enum logic [1:0] {
    ROW_FREE,
    ROW_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [2:0]  mode;
    logic        up_sw;
    logic        low_sw;
    lift_state_e st;
    lift_err_e   err;
    logic [1:0]  idx;
    logic [15:0] val;
  } script_row_t;

  localparam int SCRIPT_LEN = 32;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // Straight after reset, then a limit conflict and what the error state ignores.
    '{ROW_TYPED, MODE_TICK,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b1, 1'b1, ST_ERROR,       ERR_LIMIT_CONFLICT, CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UP,          1'b0, 1'b0, ST_ERROR,       ERR_LIMIT_CONFLICT, CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UNKNOWN_TOP, 1'b0, 1'b0, ST_ERROR,       ERR_LIMIT_CONFLICT, CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_STOP,        1'b1, 1'b1, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UNKNOWN,     1'b0, 1'b0, ST_ERROR,       ERR_INVALID,        CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_STOP,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    // Motion, end limits in and against the commanded direction.
    '{ROW_TYPED, MODE_UP,          1'b0, 1'b0, ST_MOVING_UP,   ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_FREE,  MODE_UP,          1'b0, 1'b1, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b1, 1'b0, ST_AT_TOP,      ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_DOWN,        1'b0, 1'b1, ST_AT_BOTTOM,   ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UP,          1'b1, 1'b0, ST_AT_TOP,      ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_DOWN,        1'b0, 1'b0, ST_MOVING_DOWN, ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b0, 1'b1, ST_AT_BOTTOM,   ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UP,          1'b1, 1'b1, ST_ERROR,       ERR_LIMIT_CONFLICT, CFG_MAX_UP, 16'd0},
    // Command watchdog at its smallest setting.
    '{ROW_CFG,   MODE_TICK,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_CMD_TO, 16'd0},
    '{ROW_TYPED, MODE_STOP,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_DOWN,        1'b0, 1'b0, ST_MOVING_DOWN, ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b0, 1'b0, ST_ERROR,       ERR_CMD_TIMEOUT,    CFG_MAX_UP, 16'd0},
    // Upward timeout wins over the watchdog when both fire.
    '{ROW_CFG,   MODE_TICK,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_STOP,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UP,          1'b0, 1'b0, ST_MOVING_UP,   ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b0, 1'b0, ST_ERROR,       ERR_TOP_TIMEOUT,    CFG_MAX_UP, 16'd0},
    // Downward timeout while the far switch is active.
    '{ROW_CFG,   MODE_TICK,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_DOWN, 16'd0},
    '{ROW_TYPED, MODE_STOP,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_DOWN,        1'b0, 1'b0, ST_MOVING_DOWN, ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b1, 1'b0, ST_ERROR,       ERR_BOTTOM_TIMEOUT, CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_DOWN,        1'b0, 1'b0, ST_ERROR,       ERR_BOTTOM_TIMEOUT, CFG_MAX_UP, 16'd0},
    // Reaching the end limit beats an expired timeout.
    '{ROW_TYPED, MODE_STOP,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_UP,          1'b0, 1'b0, ST_MOVING_UP,   ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_TYPED, MODE_TICK,        1'b1, 1'b0, ST_AT_TOP,      ERR_NONE,           CFG_MAX_UP, 16'd0},
    '{ROW_FREE,  MODE_TICK,        1'b0, 1'b0, ST_IDLE,        ERR_NONE,           CFG_MAX_UP, 16'd0}
  };

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = CFG_MAX_UP;
  logic [15:0] cfg_data_i    = '0;

  // Supervisor copy kept by the testbench, with the reset defaults.
  lift_state_e             lift_st       = ST_IDLE;
  lift_err_e               lift_err      = ERR_NONE;
  logic [COUNTER_BITS-1:0] motion_ms     = '0;
  logic [COUNTER_BITS-1:0] cmd_ms        = '0;
  logic [15:0]             up_limit_ms   = MAX_UP_RST;
  logic [15:0]             down_limit_ms = MAX_DOWN_RST;
  logic [15:0]             cmd_limit_ms  = CMD_TO_RST;

  las_res_t status_due[$];
  logic     steady          = 1'b0;
  int       beats_sent      = 0;
  int       results_checked = 0;
  int       mismatches      = 0;
  int       reg_writes      = 0;
  logic [7:0] states_seen   = '0;
  logic [7:0] errors_seen   = '0;

  lift_actuator_supervisor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic las_res_t status_of(input lift_state_e st, input lift_err_e err);
    las_res_t r;
    r.lift_state  = st;
    r.error_code  = err;
    r.moving      = (st == ST_MOVING_UP) || (st == ST_MOVING_DOWN);
    r.motor_drive = (st == ST_MOVING_UP) ? DRV_UP :
                    (st == ST_MOVING_DOWN) ? DRV_DOWN : DRV_STOP;
    return r;
  endfunction

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Applies one beat to the supervisor copy and returns the status it leaves.
  function automatic las_res_t lift_next(input logic [2:0] mode, input logic up_sw,
                                         input logic low_sw);
    lift_state_e target;
    if (mode == MODE_TICK) begin
      motion_ms = sat_inc(motion_ms);
      cmd_ms    = sat_inc(cmd_ms);
      if (up_sw && low_sw) begin
        lift_st = ST_ERROR;
        lift_err = ERR_LIMIT_CONFLICT;
      end else if (lift_st == ST_MOVING_UP && up_sw) begin
        lift_st = ST_AT_TOP;
        lift_err = ERR_NONE;
      end else if (lift_st == ST_MOVING_DOWN && low_sw) begin
        lift_st = ST_AT_BOTTOM;
        lift_err = ERR_NONE;
      end else if (lift_st == ST_MOVING_UP && motion_ms > up_limit_ms) begin
        lift_st = ST_ERROR;
        lift_err = ERR_TOP_TIMEOUT;
      end else if (lift_st == ST_MOVING_DOWN && motion_ms > down_limit_ms) begin
        lift_st = ST_ERROR;
        lift_err = ERR_BOTTOM_TIMEOUT;
      end else if ((lift_st == ST_MOVING_UP || lift_st == ST_MOVING_DOWN) &&
                   cmd_ms > cmd_limit_ms) begin
        lift_st = ST_ERROR;
        lift_err = ERR_CMD_TIMEOUT;
      end
    end else if (mode == MODE_STOP) begin
      motion_ms = '0;
      cmd_ms    = '0;
      lift_st   = ST_IDLE;
      lift_err  = ERR_NONE;
    end else if (lift_st == ST_ERROR) begin
      // Only a stop gets the lift out of the error state.
    end else if (mode == MODE_UP || mode == MODE_DOWN) begin
      target = (mode == MODE_UP) ? ST_MOVING_UP : ST_MOVING_DOWN;
      cmd_ms = '0;
      if (up_sw && low_sw) begin
        lift_st = ST_ERROR;
        lift_err = ERR_LIMIT_CONFLICT;
      end else if ((mode == MODE_UP) ? up_sw : low_sw) begin
        lift_st = (mode == MODE_UP) ? ST_AT_TOP : ST_AT_BOTTOM;
        lift_err = ERR_NONE;
      end else begin
        // A repeated command in the same direction keeps the motion time running.
        if (lift_st != target) motion_ms = '0;
        lift_st = target;
        lift_err = ERR_NONE;
      end
    end else begin
      lift_st = ST_ERROR;
      lift_err = ERR_INVALID;
    end
    return status_of(lift_st, lift_err);
  endfunction

  // Offers one beat, with random idle cycles ahead of it, and records the
  // status it must produce once it has been taken.
  task automatic send_beat(input logic [2:0] mode, input logic up_sw, input logic low_sw,
                           input logic typed, input las_res_t typed_res);
    las_res_t due;
    while (!steady && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, low_sw, up_sw, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    due = lift_next(mode, up_sw, low_sw);
    if (typed) due = typed_res;
    status_due.push_back(due);
    beats_sent++;
    states_seen[due.lift_state] = 1'b1;
    errors_seen[due.error_code] = 1'b1;
  endtask

  // Registers change only with the input stopped and every status returned.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_UP:   up_limit_ms   = val;
      CFG_MAX_DOWN: down_limit_ms = val;
      CFG_CMD_TO:   cmd_limit_ms  = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  // Mostly move commands followed by runs of ticks, with refreshes, end
  // limits and stray switch levels; the rest is arbitrary beats.
  task automatic run_moves(input int beats, input int span);
    int         stop_at;
    int         run_len;
    logic [2:0] dir;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 99) < 70) begin
        if (lift_st == ST_ERROR || $urandom_range(0, 3) == 0)
          send_beat(MODE_STOP, 1'b0, 1'b0, 1'b0, '0);
        dir = $urandom_range(0, 1) ? MODE_UP : MODE_DOWN;
        send_beat(dir, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0, 1'b0, '0);
        run_len = $urandom_range(0, span);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(dir, 1'b0, 1'b0, 1'b0, '0);
          else if ($urandom_range(0, 14) == 0)
            send_beat(MODE_TICK, dir == MODE_UP, dir == MODE_DOWN, 1'b0, '0);
          else
            send_beat(MODE_TICK, $urandom_range(0, 29) == 0, $urandom_range(0, 29) == 0,
                      1'b0, '0);
        end
      end else begin
        send_beat(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b0, '0);
      end
    end
  endtask

  // Result side: random stalls, and a check of every status beat taken.
  always @(posedge clk_i) begin : status_sink
    las_res_t got;
    las_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = las_res_t'(m_axis_tdata[8:0]);
      results_checked++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("Status beat %h arrived with nothing outstanding.", m_axis_tdata);
      end else begin
        want = status_due.pop_front();
        if (got !== want || m_axis_tdata[15:9] !== '0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("Status %0d: expected %0d %0d %0d %0d, got %0d %0d %0d %0d (%h).",
                     results_checked, want.motor_drive, want.lift_state, want.error_code,
                     want.moving, got.motor_drive, got.lift_state, got.error_code,
                     got.moving, m_axis_tdata);
        end
      end
    end
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG)
        write_reg(SCRIPT[i].idx, SCRIPT[i].val);
      else
        send_beat(SCRIPT[i].mode, SCRIPT[i].up_sw, SCRIPT[i].low_sw,
                  SCRIPT[i].kind == ROW_TYPED, status_of(SCRIPT[i].st, SCRIPT[i].err));
    end

    // Small limits so that timeouts and the watchdog fire inside the runs.
    write_reg(CFG_MAX_UP, 16'($urandom_range(0, 12)));
    write_reg(CFG_MAX_DOWN, 16'($urandom_range(0, 12)));
    write_reg(CFG_CMD_TO, 16'($urandom_range(0, 12)));
    run_moves(110, 16);

    // Upward motion never times out; no idling on either side here.
    write_reg(CFG_MAX_UP, CFG_TOP);
    write_reg(CFG_MAX_DOWN, 16'($urandom_range(0, 30)));
    write_reg(CFG_CMD_TO, 16'($urandom_range(5, 40)));
    steady <= 1'b1;
    run_moves(110, 45);
    steady <= 1'b0;

    write_reg(CFG_MAX_UP, '0);
    write_reg(CFG_MAX_DOWN, '0);
    write_reg(CFG_CMD_TO, '0);
    run_moves(60, 3);

    write_reg(CFG_MAX_UP, 16'($urandom_range(0, 65535)));
    write_reg(CFG_MAX_DOWN, 16'($urandom_range(0, 20)));
    write_reg(CFG_CMD_TO, 16'($urandom_range(0, 20)));
    run_moves(120, 24);

    // Largest limits: a short upward run that must keep moving, with
    // repeated up commands along the way.
    write_reg(CFG_MAX_UP, CFG_TOP);
    write_reg(CFG_MAX_DOWN, CFG_TOP);
    write_reg(CFG_CMD_TO, CFG_TOP);
    send_beat(MODE_STOP, 1'b0, 1'b0, 1'b0, '0);
    send_beat(MODE_UP, 1'b0, 1'b0, 1'b0, '0);
    for (int n = 1; n <= 40; n++)
      send_beat((n % 15 == 0) ? MODE_UP : MODE_TICK, 1'b0, 1'b0, 1'b0, '0);
    send_beat(MODE_STOP, 1'b0, 1'b0, 1'b0, '0);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d input beats over %0d register writes and checked %0d status beats.",
             beats_sent, reg_writes, results_checked);
    $display("Lift states reached %b, error codes raised %b (one bit per code).",
             states_seen[5:0], errors_seen[5:0]);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Well beyond the slowest correct run.
  initial begin : watchdog
    #(20_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
